### rtl/mglsa_pkg.sv
// Shared types, constants and fixed-point helpers of the MGLSA synthesis filter.
`default_nettype none
package mglsa_pkg;

  localparam int MGLSA_MAX_ORDER  = 31;
  localparam int MGLSA_MAX_STAGES = 8;

  localparam int DATA_W    = 32;
  localparam int ALPHA_W   = 17;
  localparam int ORDER_W   = 5;
  localparam int STAGES_W  = 4;
  localparam int CIDX_W    = 5;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0]  Q_ONE         = 32'sd65536;
  localparam logic signed [ALPHA_W-1:0] ALPHA_RESET   = 17'sd27525;
  localparam logic [ORDER_W-1:0]        ORDER_RESET   = 5'd24;
  localparam logic [STAGES_W-1:0]       STAGES_RESET  = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA      = 3'd0,
    REG_TRANSPOSED = 3'd1,
    REG_ORDER      = 3'd2,
    REG_STAGES     = 3'd3
  } reg_index_t;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [5:0] {
    UOP_NOP, UOP_START, UOP_LOAD, UOP_BETA, UOP_XLOAD, UOP_OUT,
    UOP_D0, UOP_D1, UOP_D2,
    UOP_L0, UOP_L1, UOP_L2, UOP_L3, UOP_L4, UOP_L5,
    UOP_E0, UOP_E1, UOP_E2,
    UOP_T0, UOP_T1, UOP_T2, UOP_T3, UOP_T4, UOP_T5, UOP_T6,
    UOP_U0, UOP_U1, UOP_U2, UOP_U3, UOP_U4, UOP_U5, UOP_U6
  } uop_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_BETA, ST_XLOAD,
    ST_D0, ST_D1, ST_D2,
    ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5,
    ST_E0, ST_E1, ST_E2,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6,
    ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6,
    ST_STG, ST_DONE
  } state_t;

  typedef struct packed {
    uop_t uop;
    logic clr;
  } mglsa_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] qadd(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return sat33({a[DATA_W-1], a} + {b[DATA_W-1], b});
  endfunction

  function automatic logic signed [DATA_W-1:0] qsub(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return sat33({a[DATA_W-1], a} - {b[DATA_W-1], b});
  endfunction

  // Round half up, drop 16 fraction bits, saturate.
  function automatic logic signed [DATA_W-1:0] qround(input logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [DATA_W-1:0] q;
    r = p + 64'sd32768;
    if ((&r[63:47]) || !(|r[63:47])) begin
      q = r[47:16];
    end else begin
      q = r[63] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return q;
  endfunction

endpackage
`default_nettype wire

### rtl/mglsa_ifs.sv
// Valid/ready channel interfaces: sample input, result output, register writes.
`default_nettype none
interface mglsa_in_if import mglsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [DATA_W-1:0] data_value;
  modport source (output valid, command, coef_index, data_value, input ready);
  modport sink   (input valid, command, coef_index, data_value, output ready);
endinterface

interface mglsa_out_if import mglsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered_sample;
  modport source (output valid, filtered_sample, input ready);
  modport sink   (input valid, filtered_sample, output ready);
endinterface

interface mglsa_cfg_if import mglsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DATA_W-1:0]    wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

### rtl/mglsa_dp.sv
// Datapath: coefficient and delay memories, one multiplier, saturating adder.
`default_nettype none
module mglsa_dp import mglsa_pkg::*; #(
  parameter int MAX_ORDER  = MGLSA_MAX_ORDER,
  parameter int MAX_STAGES = MGLSA_MAX_STAGES,
  localparam int CDEPTH = MAX_ORDER + 1,
  localparam int DDEPTH = (MAX_ORDER + 1) * MAX_STAGES,
  localparam int OW     = $clog2(CDEPTH),
  localparam int AW     = $clog2(DDEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mglsa_cmd_t               cmd,
  input  wire logic [AW-1:0]            dly_addr,
  input  wire logic [OW-1:0]            coef_addr,
  input  wire logic signed [ALPHA_W-1:0] alpha,
  input  wire logic [CIDX_W-1:0]        in_coef_index,
  input  wire logic signed [DATA_W-1:0] in_data_value,
  output logic signed [DATA_W-1:0]      out_sample
);

  logic signed [DATA_W-1:0] dmem [DDEPTH];
  logic signed [DATA_W-1:0] cmem [CDEPTH];
  logic [DDEPTH-1:0]        dval_r;
  logic [CDEPTH-1:0]        cval_r;

  logic signed [DATA_W-1:0] samp_r, beta_r, x_r, y_r, prev_r, cur_r, nxt_r, d0_r, tmp_r;
  logic signed [DATA_W-1:0] rdd_r, rdc_r, out_r;
  logic signed [63:0]       prod_r;

  logic signed [DATA_W-1:0] alpha_q, qm, ma, mb, wd;
  logic                     mul_en, dly_rd, dly_wr, coef_rd, coef_wr;
  logic [OW-1:0]            cwr_idx;

  assign alpha_q    = {{(DATA_W-ALPHA_W){alpha[ALPHA_W-1]}}, alpha};
  assign qm         = qround(prod_r);
  assign out_sample = out_r;
  assign cwr_idx    = OW'(in_coef_index);

  assign dly_rd  = (cmd.uop == UOP_D0) || (cmd.uop == UOP_D1) || (cmd.uop == UOP_L0) ||
                   (cmd.uop == UOP_T0) || (cmd.uop == UOP_T1) || (cmd.uop == UOP_U0);
  assign dly_wr  = (cmd.uop == UOP_L4) || (cmd.uop == UOP_E0) || (cmd.uop == UOP_E2) ||
                   (cmd.uop == UOP_T5) || (cmd.uop == UOP_T6) || (cmd.uop == UOP_U6);
  assign coef_rd = (cmd.uop == UOP_START) || (cmd.uop == UOP_D0) || (cmd.uop == UOP_L0) ||
                   (cmd.uop == UOP_T1) || (cmd.uop == UOP_U0);
  assign coef_wr = (cmd.uop == UOP_LOAD) && (int'(in_coef_index) <= MAX_ORDER);

  // multiplier operand select
  always_comb begin
    ma     = alpha_q;
    mb     = alpha_q;
    mul_en = 1'b1;
    case (cmd.uop)
      UOP_START: begin ma = alpha_q; mb = alpha_q; end
      UOP_BETA:  begin ma = samp_r;  mb = rdc_r;   end
      UOP_D1:    begin ma = rdd_r;   mb = rdc_r;   end
      UOP_L2:    begin ma = alpha_q; mb = tmp_r;   end
      UOP_L4:    begin ma = tmp_r;   mb = rdc_r;   end
      UOP_E0:    begin ma = alpha_q; mb = d0_r;    end
      UOP_E1:    begin ma = beta_r;  mb = x_r;     end
      UOP_T1:    begin ma = beta_r;  mb = rdd_r;   end
      UOP_T2:    begin ma = alpha_q; mb = rdd_r;   end
      UOP_T3:    begin ma = rdc_r;   mb = x_r;     end
      UOP_U2:    begin ma = alpha_q; mb = tmp_r;   end
      UOP_U3:    begin ma = rdc_r;   mb = x_r;     end
      default:   mul_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.uop)
      UOP_E0:  wd = d0_r;
      UOP_E2:  wd = qadd(tmp_r, qm);
      default: wd = tmp_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dval_r <= '0;
      cval_r <= '0;
    end else begin
      if (cmd.clr) begin
        dval_r <= '0;
      end else if (dly_wr) begin
        dval_r[dly_addr] <= 1'b1;
      end
      if (coef_wr) begin
        cval_r[cwr_idx] <= 1'b1;
      end
    end
  end

  // memories; an unwritten word reads as zero
  always_ff @(posedge clk) begin
    if (dly_wr) begin
      dmem[dly_addr] <= wd;
    end
    if (dly_rd) begin
      rdd_r <= dval_r[dly_addr] ? dmem[dly_addr] : '0;
    end
    if (coef_wr) begin
      cmem[cwr_idx] <= in_data_value;
    end
    if (coef_rd) begin
      rdc_r <= cval_r[coef_addr] ? cmem[coef_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= ma * mb;
    end
    case (cmd.uop)
      UOP_START: samp_r <= in_data_value;
      UOP_BETA:  beta_r <= qsub(Q_ONE, qm);
      UOP_XLOAD: x_r    <= qm;
      UOP_D1:    begin d0_r <= rdd_r; prev_r <= rdd_r; end
      UOP_D2:    begin y_r <= qm; cur_r <= rdd_r; end
      UOP_L1:    begin nxt_r <= rdd_r; tmp_r <= qsub(rdd_r, prev_r); end
      UOP_L3:    tmp_r <= qadd(cur_r, qm);
      UOP_L4:    begin prev_r <= tmp_r; cur_r <= nxt_r; end
      UOP_L5:    y_r   <= qadd(y_r, qm);
      UOP_E0:    x_r   <= qsub(x_r, y_r);
      UOP_E1:    tmp_r <= qm;
      UOP_T2:    begin x_r <= qsub(x_r, qm); nxt_r <= rdd_r; end
      UOP_T3:    tmp_r <= qm;
      UOP_T4:    tmp_r <= qadd(qm, tmp_r);
      UOP_T5:    begin prev_r <= tmp_r; cur_r <= nxt_r; end
      UOP_U1:    begin tmp_r <= qsub(rdd_r, prev_r); nxt_r <= rdd_r; end
      UOP_U3:    tmp_r <= qm;
      UOP_U4:    tmp_r <= qadd(qm, tmp_r);
      UOP_U5:    tmp_r <= qadd(cur_r, tmp_r);
      UOP_U6:    begin prev_r <= tmp_r; cur_r <= nxt_r; end
      UOP_OUT:   out_r <= x_r;
      default:   ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/mglsa_ctrl.sv
// Controller: config registers, sequencer FSM, stage and tap counters, handshakes.
`default_nettype none
module mglsa_ctrl import mglsa_pkg::*; #(
  parameter int MAX_ORDER  = MGLSA_MAX_ORDER,
  parameter int MAX_STAGES = MGLSA_MAX_STAGES,
  localparam int OW = $clog2(MAX_ORDER + 1),
  localparam int SW = $clog2(MAX_STAGES + 1),
  localparam int AW = $clog2((MAX_ORDER + 1) * MAX_STAGES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CMD_W-1:0]      in_command,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0]     cfg_data,
  output mglsa_cmd_t                 cmd,
  output logic [AW-1:0]              dly_addr,
  output logic [OW-1:0]              coef_addr,
  output logic signed [ALPHA_W-1:0]  alpha
);

  state_t state_r, state_nxt;
  logic [OW-1:0] j_r, j_nxt;
  logic [SW-1:0] stage_r, stage_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic signed [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic                      tf_r, tf_nxt;
  logic [ORDER_W-1:0]        order_r, order_nxt;
  logic [STAGES_W-1:0]       stages_r, stages_nxt;
  logic                      cfg_clr;

  logic          accept, out_free;
  logic [OW-1:0] m_eff;
  logic [SW-1:0] ns_eff;
  logic [AW-1:0] m_ext, j_ext;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign alpha     = alpha_r;
  assign out_free  = !out_valid_r || out_ready;

  assign m_eff  = (int'(order_r) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(order_r);
  assign ns_eff = (stages_r == '0) ? SW'(1) :
                  (int'(stages_r) > MAX_STAGES) ? SW'(MAX_STAGES) : SW'(stages_r);
  assign m_ext  = AW'(m_eff);
  assign j_ext  = AW'(j_r);

  // register writes; order or stage change flushes the delays
  always_comb begin
    alpha_nxt  = alpha_r;
    tf_nxt     = tf_r;
    order_nxt  = order_r;
    stages_nxt = stages_r;
    cfg_clr    = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ALPHA:      alpha_nxt = cfg_data[ALPHA_W-1:0];
        REG_TRANSPOSED: tf_nxt    = cfg_data[0];
        REG_ORDER: begin
          order_nxt = cfg_data[ORDER_W-1:0];
          cfg_clr   = (cfg_data[ORDER_W-1:0] != order_r);
        end
        REG_STAGES: begin
          stages_nxt = cfg_data[STAGES_W-1:0];
          cfg_clr    = (cfg_data[STAGES_W-1:0] != stages_r);
        end
        default: ;
      endcase
    end
  end

  // next state and counters
  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    stage_nxt     = stage_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE:  if (accept && (in_command == CMD_SAMPLE)) state_nxt = ST_BETA;
      ST_BETA:  state_nxt = ST_XLOAD;
      ST_XLOAD: begin
        stage_nxt = '0;
        base_nxt  = '0;
        if (m_eff == '0)  state_nxt = ST_DONE;
        else if (tf_r)    state_nxt = ST_T0;
        else              state_nxt = ST_D0;
      end
      ST_D0: state_nxt = ST_D1;
      ST_D1: state_nxt = ST_D2;
      ST_D2: begin
        j_nxt     = OW'(1);
        state_nxt = (m_eff == OW'(1)) ? ST_E0 : ST_L0;
      end
      ST_L0: state_nxt = ST_L1;
      ST_L1: state_nxt = ST_L2;
      ST_L2: state_nxt = ST_L3;
      ST_L3: state_nxt = ST_L4;
      ST_L4: state_nxt = ST_L5;
      ST_L5: begin
        j_nxt     = j_r + OW'(1);
        state_nxt = (j_r + OW'(1) == m_eff) ? ST_E0 : ST_L0;
      end
      ST_E0: state_nxt = ST_E1;
      ST_E1: state_nxt = ST_E2;
      ST_E2: state_nxt = ST_STG;
      ST_T0: state_nxt = ST_T1;
      ST_T1: state_nxt = ST_T2;
      ST_T2: state_nxt = ST_T3;
      ST_T3: state_nxt = ST_T4;
      ST_T4: state_nxt = ST_T5;
      ST_T5: state_nxt = ST_T6;
      ST_T6: begin
        j_nxt     = m_eff - OW'(1);
        state_nxt = (m_eff == OW'(1)) ? ST_STG : ST_U0;
      end
      ST_U0: state_nxt = ST_U1;
      ST_U1: state_nxt = ST_U2;
      ST_U2: state_nxt = ST_U3;
      ST_U3: state_nxt = ST_U4;
      ST_U4: state_nxt = ST_U5;
      ST_U5: state_nxt = ST_U6;
      ST_U6: begin
        j_nxt     = j_r - OW'(1);
        state_nxt = (j_r == OW'(1)) ? ST_STG : ST_U0;
      end
      ST_STG: begin
        stage_nxt = stage_r + SW'(1);
        base_nxt  = base_r + m_ext + AW'(1);
        if (stage_r + SW'(1) == ns_eff) state_nxt = ST_DONE;
        else if (tf_r)                  state_nxt = ST_T0;
        else                            state_nxt = ST_D0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands and addresses
  always_comb begin
    cmd.uop   = UOP_NOP;
    cmd.clr   = cfg_clr || (accept && (in_command == CMD_CLEAR));
    dly_addr  = base_r;
    coef_addr = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_SAMPLE)) cmd.uop = UOP_START;
        else if (accept && (in_command == CMD_LOAD)) cmd.uop = UOP_LOAD;
      end
      ST_BETA:  cmd.uop = UOP_BETA;
      ST_XLOAD: cmd.uop = UOP_XLOAD;
      ST_D0: begin cmd.uop = UOP_D0; coef_addr = OW'(1); end
      ST_D1: begin cmd.uop = UOP_D1; dly_addr = base_r + AW'(1); end
      ST_D2: cmd.uop = UOP_D2;
      ST_L0: begin
        cmd.uop   = UOP_L0;
        dly_addr  = base_r + j_ext + AW'(1);
        coef_addr = j_r + OW'(1);
      end
      ST_L1: cmd.uop = UOP_L1;
      ST_L2: cmd.uop = UOP_L2;
      ST_L3: cmd.uop = UOP_L3;
      ST_L4: begin cmd.uop = UOP_L4; dly_addr = base_r + j_ext + AW'(1); end
      ST_L5: cmd.uop = UOP_L5;
      ST_E0: begin cmd.uop = UOP_E0; dly_addr = base_r + AW'(1); end
      ST_E1: cmd.uop = UOP_E1;
      ST_E2: cmd.uop = UOP_E2;
      ST_T0: cmd.uop = UOP_T0;
      ST_T1: begin
        cmd.uop   = UOP_T1;
        dly_addr  = base_r + m_ext - AW'(1);
        coef_addr = m_eff;
      end
      ST_T2: cmd.uop = UOP_T2;
      ST_T3: cmd.uop = UOP_T3;
      ST_T4: cmd.uop = UOP_T4;
      ST_T5: begin cmd.uop = UOP_T5; dly_addr = base_r + m_ext; end
      ST_T6: begin cmd.uop = UOP_T6; dly_addr = base_r + m_ext - AW'(1); end
      ST_U0: begin
        cmd.uop   = UOP_U0;
        dly_addr  = base_r + j_ext - AW'(1);
        coef_addr = j_r;
      end
      ST_U1: cmd.uop = UOP_U1;
      ST_U2: cmd.uop = UOP_U2;
      ST_U3: cmd.uop = UOP_U3;
      ST_U4: cmd.uop = UOP_U4;
      ST_U5: cmd.uop = UOP_U5;
      ST_U6: begin cmd.uop = UOP_U6; dly_addr = base_r + j_ext - AW'(1); end
      ST_DONE: if (out_free) cmd.uop = UOP_OUT;
      default: cmd.uop = UOP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      stage_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= ALPHA_RESET;
      tf_r        <= 1'b0;
      order_r     <= ORDER_RESET;
      stages_r    <= STAGES_RESET;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      stage_r     <= stage_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      alpha_r     <= alpha_nxt;
      tf_r        <= tf_nxt;
      order_r     <= order_nxt;
      stages_r    <= stages_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/mglsa_synthesis_filter_unit.sv
// Top level of the MGLSA synthesis filter: controller plus datapath.
//
//  channel   dir  word                                       accepted when
//  in_bus    in   command, coef_index, data_value            valid & ready
//  out_bus   out  filtered_sample                            valid & ready
//  cfg_bus   in   reg_index, wr_data                         valid & ready
//
// Load, clear and no-op words are handled without leaving the idle
// state. A sample word runs through ns stages of order M in direct
// or transposed form: one shared multiplier and single-port delay
// memory walk each tap in six or seven steps. Order zero gives the
// gain product with no stage pass.
// Reset is synchronous; delay and coefficient words read as zero until
// written, via valid bits, so no clearing pass is needed.
// A finished sample sits in the output register; a new word is taken once
// that register is loaded, even while the result still waits downstream.
`default_nettype none
module mglsa_synthesis_filter_unit import mglsa_pkg::*; #(
  parameter int MAX_ORDER  = MGLSA_MAX_ORDER,
  parameter int MAX_STAGES = MGLSA_MAX_STAGES
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mglsa_in_if.sink   in_bus,
  mglsa_out_if.source out_bus,
  mglsa_cfg_if.sink  cfg_bus
);

  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int AW = $clog2((MAX_ORDER + 1) * MAX_STAGES);

  mglsa_cmd_t                cmd;
  logic [AW-1:0]             dly_addr;
  logic [OW-1:0]             coef_addr;
  logic signed [ALPHA_W-1:0] alpha;

  // sequencer; also owns the config registers
  mglsa_ctrl #(
    .MAX_ORDER  (MAX_ORDER),
    .MAX_STAGES (MAX_STAGES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_command (in_bus.command),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .cfg_valid  (cfg_bus.valid),
    .cfg_ready  (cfg_bus.ready),
    .cfg_index  (cfg_bus.reg_index),
    .cfg_data   (cfg_bus.wr_data),
    .cmd        (cmd),
    .dly_addr   (dly_addr),
    .coef_addr  (coef_addr),
    .alpha      (alpha)
  );

  // memories and arithmetic
  mglsa_dp #(
    .MAX_ORDER  (MAX_ORDER),
    .MAX_STAGES (MAX_STAGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .dly_addr      (dly_addr),
    .coef_addr     (coef_addr),
    .alpha         (alpha),
    .in_coef_index (in_bus.coef_index),
    .in_data_value (in_bus.data_value),
    .out_sample    (out_bus.filtered_sample)
  );

endmodule
`default_nettype wire
